// ----- hdl/nps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned SLOT_W    = $clog2(SLOTS);
  localparam int unsigned CNT_W     = $clog2(SLOTS + 2);
  localparam int unsigned SEQ_W     = 16;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned BURST_W   = 16;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  localparam logic EV_DONE     = 1'b0;
  localparam logic EV_DROP     = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [PRIO_W-1:0]    prio;
    logic [BURST_W-1:0]   burst;
    logic [TIME_BITS-1:0] arrival;
    logic [SEQ_W-1:0]     seq;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    entry_t            entry;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
  } slot_req_t;

  typedef struct packed {
    logic   vld;
    entry_t entry;
  } rd_data_t;

  typedef struct packed {
    logic                 found;
    logic [SLOT_W-1:0]    idx;
    logic [ID_W-1:0]      id;
    logic [BURST_W-1:0]   burst;
    logic [TIME_BITS-1:0] arrival;
  } best_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARRIVE,
    S_TICK,
    S_SCAN,
    S_ADV
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/nps_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface nps_in_if import nps_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [ID_W-1:0]    job_id;
  logic [PRIO_W-1:0]  job_priority;
  logic [BURST_W-1:0] job_burst;

  modport source (output valid, output kind, output job_id, output job_priority,
                  output job_burst, input ready);
  modport sink   (input valid, input kind, input job_id, input job_priority,
                  input job_burst, output ready);
endinterface

interface nps_out_if import nps_pkg::*;;
  logic             valid;
  logic             ready;
  logic             event_res;
  logic [ID_W-1:0]  done_id;
  logic [OUT_W-1:0] start_time;
  logic [OUT_W-1:0] finish_time;
  logic [OUT_W-1:0] turnaround;
  logic [OUT_W-1:0] waiting;

  modport source (output valid, output event_res, output done_id, output start_time,
                  output finish_time, output turnaround, output waiting, input ready);
  modport sink   (input valid, input event_res, input done_id, input start_time,
                  input finish_time, input turnaround, input waiting, output ready);
endinterface

`default_nettype wire

// ----- hdl/nps_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nps_store import nps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wr_req_t           wr_i,
  input  slot_req_t         clr_i,
  input  slot_req_t         rd_i,
  output rd_data_t          rd_o,
  output logic              free_found_o,
  output logic [SLOT_W-1:0] free_idx_o
);

  logic [SLOTS-1:0] valid_q;
  entry_t           mem_q [SLOTS];
  rd_data_t         rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.idx] <= 1'b1;
      end
      if (clr_i.en) begin
        valid_q[clr_i.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.entry;
    end
    if (rd_i.en) begin
      rd_q.entry <= mem_q[rd_i.idx];
      rd_q.vld   <= valid_q[rd_i.idx];
    end
  end

  assign rd_o = rd_q;

  // Lowest-numbered free slot takes the next arrival.
  always_comb begin
    free_found_o = 1'b0;
    free_idx_o   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found_o = 1'b1;
        free_idx_o   = SLOT_W'(i);
      end
    end
  end

  a_wr_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |-> !valid_q[wr_i.idx])
    else $error("write into an occupied slot");

  a_clr_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i.en |-> valid_q[clr_i.idx])
    else $error("dispatch from an empty slot");

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i.en && clr_i.en))
    else $error("arrival write and dispatch in the same cycle");

endmodule

`default_nettype wire

// ----- hdl/nps_pick.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nps_pick import nps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  slot_req_t        iss_i,
  input  rd_data_t         rd_i,
  input  logic [SEQ_W-1:0] seq_i,
  output best_t            best_o
);

  slot_req_t         iss_q;
  best_t             best_q;
  logic [PRIO_W-1:0] best_prio_q;
  logic [SEQ_W-1:0]  best_age_q;
  logic [SEQ_W-1:0]  age;
  logic              take;

  // Age is taken relative to the current sequence count so that a wrapped
  // sequence number still orders recent arrivals correctly.
  assign age  = seq_i - rd_i.entry.seq;
  assign take = iss_q.en && rd_i.vld &&
                (!best_q.found || (rd_i.entry.prio > best_prio_q) ||
                 ((rd_i.entry.prio == best_prio_q) && (age > best_age_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q       <= '0;
      best_q      <= '0;
      best_prio_q <= '0;
      best_age_q  <= '0;
    end else begin
      iss_q <= iss_i;
      if (clr_i) begin
        best_q.found <= 1'b0;
      end else if (take) begin
        best_q.found   <= 1'b1;
        best_q.idx     <= iss_q.idx;
        best_q.id      <= rd_i.entry.id;
        best_q.burst   <= rd_i.entry.burst;
        best_q.arrival <= rd_i.entry.arrival;
        best_prio_q    <= rd_i.entry.prio;
        best_age_q     <= age;
      end
    end
  end

  assign best_o = best_q;

endmodule

`default_nettype wire

// ----- hdl/nonpreemptive_priority_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Interface   Payload
// in_i     in   nps_in_if   kind, job_id, job_priority, job_burst
// res_o    out  nps_out_if  event_res, done_id, start_time, finish_time,
//                           turnaround, waiting
//
// An arrival passes through S_ARRIVE. A tick that leaves the running job running
// passes through S_TICK and S_ADV; any other tick also passes through S_SCAN,
// which reads the ready store one entry per cycle through its port to find a
// job to dispatch, whether or not a job is found.
// Reset clears all control state and the slot valid bits at once; no sweep.
// A result beat waits in the output register while the next item is taken; an
// item that has a result to give holds only while that register stays full.

module nonpreemptive_priority_scheduler import nps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  nps_in_if.sink    in_i,
  nps_out_if.source res_o
);

  localparam logic [CNT_W-1:0] SCAN_RD   = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(SLOTS + 1);

  state_e               state_q, state_d;
  logic [SEQ_W-1:0]     seq_q, seq_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic                 busy_q, busy_d;
  logic [ID_W-1:0]      run_job_q, run_job_d;
  logic [TIME_BITS-1:0] run_start_q, run_start_d;
  logic [TIME_BITS-1:0] run_arrival_q, run_arrival_d;
  logic [BURST_W-1:0]   run_burst_q, run_burst_d;
  logic [BURST_W-1:0]   run_prog_q, run_prog_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic [ID_W-1:0]      item_id_q;
  logic [PRIO_W-1:0]    item_prio_q;
  logic [BURST_W-1:0]   item_burst_q;

  logic                 out_valid_q;
  logic                 out_ev_q;
  logic [ID_W-1:0]      out_id_q;
  logic [OUT_W-1:0]     out_start_q, out_fin_q, out_tat_q, out_wait_q;

  logic                 out_load;
  logic                 ld_ev;
  logic [ID_W-1:0]      ld_id;
  logic [OUT_W-1:0]     ld_start, ld_fin, ld_tat, ld_wait;

  logic                 accept, out_free, retire;
  logic [TIME_BITS-1:0] tat_full, wait_full;

  wr_req_t              wr_req;
  slot_req_t            clr_req, rd_req;
  rd_data_t             rd_data;
  logic                 pick_clr;
  best_t                best;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;

  nps_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr_req),
    .clr_i       (clr_req),
    .rd_i        (rd_req),
    .rd_o        (rd_data),
    .free_found_o(free_found),
    .free_idx_o  (free_idx)
  );

  nps_pick u_pick (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .clr_i (pick_clr),
    .iss_i (rd_req),
    .rd_i  (rd_data),
    .seq_i (seq_q),
    .best_o(best)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || res_o.ready;
  assign retire     = busy_q && (run_prog_q == run_burst_q);
  assign tat_full   = now_q - run_arrival_q;
  assign wait_full  = run_start_q - run_arrival_q;

  always_comb begin
    state_d       = state_q;
    seq_d         = seq_q;
    now_d         = now_q;
    busy_d        = busy_q;
    run_job_d     = run_job_q;
    run_start_d   = run_start_q;
    run_arrival_d = run_arrival_q;
    run_burst_d   = run_burst_q;
    run_prog_d    = run_prog_q;
    cnt_d         = cnt_q;
    out_load      = 1'b0;
    ld_ev         = EV_DONE;
    ld_id         = '0;
    ld_start      = '0;
    ld_fin        = '0;
    ld_tat        = '0;
    ld_wait       = '0;
    wr_req        = '0;
    clr_req       = '0;
    rd_req        = '0;
    pick_clr      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_i.kind == KIND_ARRIVE) ? S_ARRIVE : S_TICK;
        end
      end
      S_ARRIVE: begin
        if (free_found) begin
          wr_req.en            = 1'b1;
          wr_req.idx           = free_idx;
          wr_req.entry.id      = item_id_q;
          wr_req.entry.prio    = item_prio_q;
          wr_req.entry.burst   = (item_burst_q == '0) ? BURST_W'(1) : item_burst_q;
          wr_req.entry.arrival = now_q;
          wr_req.entry.seq     = seq_q;
          seq_d                = seq_q + SEQ_W'(1);
          state_d              = S_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          ld_ev    = EV_DROP;
          ld_id    = item_id_q;
          state_d  = S_IDLE;
        end
      end
      S_TICK: begin
        if (retire) begin
          if (out_free) begin
            out_load = 1'b1;
            ld_ev    = EV_DONE;
            ld_id    = run_job_q;
            ld_start = OUT_W'(run_start_q);
            ld_fin   = OUT_W'(now_q);
            ld_tat   = OUT_W'(tat_full);
            ld_wait  = OUT_W'(wait_full);
            busy_d   = 1'b0;
            cnt_d    = '0;
            pick_clr = 1'b1;
            state_d  = S_SCAN;
          end
        end else if (busy_q) begin
          state_d = S_ADV;
        end else begin
          cnt_d    = '0;
          pick_clr = 1'b1;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        // Reads go out while the count is below SLOTS; the picker compares each entry in
        // the cycle after its read, so the winner is settled at the last count.
        if (cnt_q < SCAN_RD) begin
          rd_req.en  = 1'b1;
          rd_req.idx = cnt_q[SLOT_W-1:0];
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == SCAN_LAST) begin
          if (best.found) begin
            clr_req.en    = 1'b1;
            clr_req.idx   = best.idx;
            busy_d        = 1'b1;
            run_job_d     = best.id;
            run_start_d   = now_q;
            run_arrival_d = best.arrival;
            run_burst_d   = best.burst;
            run_prog_d    = '0;
          end
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        if (busy_q) begin
          run_prog_d = run_prog_q + BURST_W'(1);
        end
        now_d   = now_q + TIME_BITS'(1);
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      seq_q         <= '0;
      now_q         <= '0;
      busy_q        <= 1'b0;
      run_job_q     <= '0;
      run_start_q   <= '0;
      run_arrival_q <= '0;
      run_burst_q   <= '0;
      run_prog_q    <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      seq_q         <= seq_d;
      now_q         <= now_d;
      busy_q        <= busy_d;
      run_job_q     <= run_job_d;
      run_start_q   <= run_start_d;
      run_arrival_q <= run_arrival_d;
      run_burst_q   <= run_burst_d;
      run_prog_q    <= run_prog_d;
      cnt_q         <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_id_q    <= in_i.job_id;
      item_prio_q  <= in_i.job_priority;
      item_burst_q <= in_i.job_burst;
    end
    if (out_load) begin
      out_ev_q    <= ld_ev;
      out_id_q    <= ld_id;
      out_start_q <= ld_start;
      out_fin_q   <= ld_fin;
      out_tat_q   <= ld_tat;
      out_wait_q  <= ld_wait;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.event_res   = out_ev_q;
  assign res_o.done_id     = out_id_q;
  assign res_o.start_time  = out_start_q;
  assign res_o.finish_time = out_fin_q;
  assign res_o.turnaround  = out_tat_q;
  assign res_o.waiting     = out_wait_q;

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || res_o.ready))
    else $error("result register overwritten before its beat was taken");

  a_prog_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (run_prog_q <= run_burst_q))
    else $error("running job served past its burst");

  a_dispatch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cnt_q == SCAN_LAST && best.found) |=> busy_q)
    else $error("dispatch did not start the processor");

endmodule

`default_nettype wire

// ----- tb/sched_checker.sv -----
`timescale 1ns / 1ps

module sched_checker import nps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  nps_in_if           in_mon,
  nps_out_if          res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic             ev;
    logic [ID_W-1:0]  id;
    logic [OUT_W-1:0] start_t;
    logic [OUT_W-1:0] finish_t;
    logic [OUT_W-1:0] turnaround;
    logic [OUT_W-1:0] waiting;
  } job_report_t;

  // Shadow copy of the scheduler state.
  entry_t               ready_store [SLOTS];
  logic [SLOTS-1:0]     ready_used;
  logic [SEQ_W-1:0]     next_seq;
  logic [TIME_BITS-1:0] sched_now;
  logic                 cpu_busy;
  logic [ID_W-1:0]      cur_id;
  logic [TIME_BITS-1:0] cur_start;
  logic [TIME_BITS-1:0] cur_arrival;
  logic [BURST_W-1:0]   cur_need;
  logic [BURST_W-1:0]   cur_served;

  job_report_t          job_reports_q [$];
  job_report_t          seen_beat;
  int unsigned          fail_total = 0;

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t sched check: %s: got %0h, want %0h", $time, what, got, want);
    fail_total++;
  endtask

  task automatic admit_job(input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio,
                           input logic [BURST_W-1:0] burst);
    int          slot;
    job_report_t drop;
    slot = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!ready_used[i]) slot = i;
    end
    if (slot < 0) begin
      drop    = '0;
      drop.ev = EV_DROP;
      drop.id = id;
      job_reports_q.push_back(drop);
    end else begin
      ready_store[slot].id      = id;
      ready_store[slot].prio    = prio;
      ready_store[slot].burst   = (burst == '0) ? BURST_W'(1) : burst;
      ready_store[slot].arrival = sched_now;
      ready_store[slot].seq     = next_seq;
      ready_used[slot]          = 1'b1;
      next_seq                  = next_seq + 1'b1;
    end
  endtask

  // Highest priority wins; on equal priority the entry that has waited through
  // the most later arrivals goes first.
  task automatic dispatch_best();
    int               best;
    logic [SEQ_W-1:0] age;
    logic [SEQ_W-1:0] best_age;
    best     = -1;
    best_age = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (ready_used[i]) begin
        age = next_seq - ready_store[i].seq;
        if (best < 0 || ready_store[i].prio > ready_store[best].prio ||
            (ready_store[i].prio == ready_store[best].prio && age > best_age)) begin
          best     = i;
          best_age = age;
        end
      end
    end
    if (best >= 0) begin
      ready_used[best] = 1'b0;
      cpu_busy         = 1'b1;
      cur_id           = ready_store[best].id;
      cur_start        = sched_now;
      cur_arrival      = ready_store[best].arrival;
      cur_need         = ready_store[best].burst;
      cur_served       = '0;
    end
  endtask

  task automatic advance_time();
    job_report_t          done;
    logic [TIME_BITS-1:0] span;
    logic [TIME_BITS-1:0] delay;
    if (cpu_busy && cur_served == cur_need) begin
      span            = sched_now - cur_arrival;
      delay           = cur_start - cur_arrival;
      done.ev         = EV_DONE;
      done.id         = cur_id;
      done.start_t    = OUT_W'(cur_start);
      done.finish_t   = OUT_W'(sched_now);
      done.turnaround = OUT_W'(span);
      done.waiting    = OUT_W'(delay);
      job_reports_q.push_back(done);
      cpu_busy = 1'b0;
    end
    if (!cpu_busy) dispatch_best();
    if (cpu_busy) cur_served = cur_served + 1'b1;
    sched_now = sched_now + 1'b1;
  endtask

  task automatic check_beat(input job_report_t got);
    job_report_t want;
    if (job_reports_q.size() == 0) begin
      flag("result beat with nothing expected, done_id", got.id, '0);
    end else begin
      want = job_reports_q.pop_front();
      if (got.ev != want.ev) flag("event_res", got.ev, want.ev);
      if (got.id != want.id) flag("done_id", got.id, want.id);
      if (got.start_t != want.start_t) flag("start_time", got.start_t, want.start_t);
      if (got.finish_t != want.finish_t) flag("finish_time", got.finish_t, want.finish_t);
      if (got.turnaround != want.turnaround) begin
        flag("turnaround", got.turnaround, want.turnaround);
      end
      if (got.waiting != want.waiting) flag("waiting", got.waiting, want.waiting);
    end
  endtask

  // Inputs are taken before outputs so that a beat accepted on the same edge
  // as an item is always matched against older expectations.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_used  = '0;
      next_seq    = '0;
      sched_now   = '0;
      cpu_busy    = 1'b0;
      cur_id      = '0;
      cur_start   = '0;
      cur_arrival = '0;
      cur_need    = '0;
      cur_served  = '0;
      job_reports_q.delete();
      pending_o    <= 0;
      fail_count_o <= fail_total;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_ARRIVE) begin
          admit_job(in_mon.job_id, in_mon.job_priority, in_mon.job_burst);
        end else begin
          advance_time();
        end
      end
      if (res_mon.valid && res_mon.ready) begin
        seen_beat.ev         = res_mon.event_res;
        seen_beat.id         = res_mon.done_id;
        seen_beat.start_t    = res_mon.start_time;
        seen_beat.finish_t   = res_mon.finish_time;
        seen_beat.turnaround = res_mon.turnaround;
        seen_beat.waiting    = res_mon.waiting;
        check_beat(seen_beat);
      end
      pending_o    <= job_reports_q.size();
      fail_count_o <= fail_total;
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import nps_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned RANDOM_ITEMS = 1100;
  // Long enough that later arrivals queue behind the running job for a while.
  localparam int unsigned LONG_TICKS   = 160;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        calm;
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending_reports;

  nps_in_if  in_bus ();
  nps_out_if res_bus ();

  nonpreemptive_priority_scheduler DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .res_o  (res_bus)
  );

  sched_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_bus),
    .res_mon      (res_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending_reports)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("nonpreemptive_priority_scheduler: mismatch");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm || $urandom_range(0, 3) != 0) begin
      res_bus.ready <= 1'b1;
    end else begin
      res_bus.ready <= 1'b0;
      stall_left    <= idle_len();
    end
  end

  // Valid stays high from one beat to the next unless a gap is taken.
  task automatic send_item(input logic kind, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio, input logic [BURST_W-1:0] burst);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.kind         <= kind;
    in_bus.job_id       <= id;
    in_bus.job_priority <= prio;
    in_bus.job_burst    <= burst;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic arrive(input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio,
                        input logic [BURST_W-1:0] burst);
    send_item(KIND_ARRIVE, id, prio, burst);
  endtask

  // The job fields ride along as noise; a tick must ignore them.
  task automatic tick();
    send_item(KIND_TICK, ID_W'($urandom), PRIO_W'($urandom), BURST_W'($urandom));
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned          arrive_pct;
    int unsigned          r;
    logic [PRIO_W-1:0]    prio;
    logic [BURST_W-1:0]   burst;
    arrive_pct = 20;
    for (int unsigned k = 0; k < n; k++) begin
      // Each stretch either fills the store, keeps it level or drains it.
      if (k % 100 == 0) begin
        calm <= ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 2))
          0: arrive_pct = 10;
          1: arrive_pct = 20;
          default: arrive_pct = 45;
        endcase
      end
      if ($urandom_range(0, 99) < arrive_pct) begin
        // A narrow priority range makes ties common.
        prio = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3))
                                           : PRIO_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 10)      burst = '0;
        else if (r < 90) burst = BURST_W'($urandom_range(1, 6));
        else if (r < 98) burst = BURST_W'($urandom_range(7, 20));
        else             burst = BURST_W'($urandom_range(21, 60));
        arrive(ID_W'($urandom_range(0, 15)), prio, burst);
      end else begin
        tick();
      end
    end
  endtask

  initial begin
    in_bus.valid        = 1'b0;
    in_bus.kind         = KIND_ARRIVE;
    in_bus.job_id       = '0;
    in_bus.job_priority = '0;
    in_bus.job_burst    = '0;
    res_bus.ready       = 1'b0;
    calm                = 1'b0;
    rst_ni              = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Nothing is ready yet, so this tick only moves the clock on.
    tick();
    // Fill every slot: extreme and tied priorities, zero bursts, and the last
    // slot reusing an id that is already waiting.
    for (int i = 0; i < SLOTS; i++) begin
      arrive((i == SLOTS - 1) ? ID_W'(3) : ID_W'(i),
             (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : PRIO_W'(i * 16 + 1),
             BURST_W'(i % 4));
    end
    // The store is full, so this one is turned away.
    arrive(ID_W'(15), 8'h80, 16'd5);
    repeat (6) tick();

    run_random(RANDOM_ITEMS / 2);

    // Empty the store, then run one long job while others queue behind it.
    calm <= 1'b1;
    repeat (200) tick();
    arrive(ID_W'(10), 8'd200, 16'd150);
    tick();
    arrive(ID_W'(3), 8'hFF, 16'd2);
    arrive(ID_W'(12), 8'hFF, 16'd1);
    arrive(ID_W'(1), 8'h00, 16'd0);
    repeat (LONG_TICKS) tick();

    run_random(RANDOM_ITEMS / 2);
    in_bus.valid <= 1'b0;

    do @(posedge clk_i); while (pending_reports != 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("nonpreemptive_priority_scheduler: match");
    end else begin
      $display("nonpreemptive_priority_scheduler: mismatch");
    end
    $finish;
  end

endmodule

// ----- nonpreemptive_priority_scheduler.f -----
hdl/nps_pkg.sv
hdl/nps_if.sv
hdl/nps_store.sv
hdl/nps_pick.sv
hdl/nonpreemptive_priority_scheduler.sv
tb/sched_checker.sv
tb/testbench.sv
